[rtl/lr_pkg.sv]
// package with shared types, constants and helpers of the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

  localparam int COORD_W    = 9;
  localparam int ERR_W      = 12;
  localparam int FRAME_SIZE = 512;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                    start;
    coord_t                  major_pos;
    coord_t                  major_end;
    coord_t                  minor_pos;
    coord_t                  major_delta;
    coord_t                  minor_delta;
    logic                    minor_down;
    logic                    axes_swapped;
    logic signed [ERR_W-1:0] error_init;
  } cmd_t;

  function automatic coord_t clip_coord(input coord_t v);
    logic [COORD_W+3:0] wide;
    wide = {4'b0, v};
    if (wide >= (COORD_W+4)'(FRAME_SIZE)) begin
      return COORD_W'(FRAME_SIZE - 1);
    end
    return v;
  endfunction

endpackage

[rtl/lr_front.sv]
// front end: classifies requests and sets up a line from its endpoints
`timescale 1ns / 1ps

module lr_front (
  input  logic           req_type,
  input  lr_pkg::coord_t from_x,
  input  lr_pkg::coord_t from_y,
  input  lr_pkg::coord_t to_x,
  input  lr_pkg::coord_t to_y,
  output lr_pkg::cmd_t   cmd
);

  lr_pkg::coord_t fx, fy, tx, ty;
  lr_pkg::coord_t adx, ady;
  lr_pkg::coord_t mj0, mj1, mn0, mn1;
  logic           y_major;
  logic           down;
  lr_pkg::coord_t mn_delta;

  always_comb begin
    fx = lr_pkg::clip_coord(from_x);
    fy = lr_pkg::clip_coord(from_y);
    tx = lr_pkg::clip_coord(to_x);
    ty = lr_pkg::clip_coord(to_y);
    adx = (fx > tx) ? fx - tx : tx - fx;
    ady = (fy > ty) ? fy - ty : ty - fy;
    y_major = !(ady < adx);
    if (!y_major) begin
      if (fx > tx) begin
        mj0 = tx; mj1 = fx; mn0 = ty; mn1 = fy;
      end else begin
        mj0 = fx; mj1 = tx; mn0 = fy; mn1 = ty;
      end
    end else begin
      if (fy > ty) begin
        mj0 = ty; mj1 = fy; mn0 = tx; mn1 = fx;
      end else begin
        mj0 = fy; mj1 = ty; mn0 = fx; mn1 = tx;
      end
    end
    down     = mn1 < mn0;
    mn_delta = down ? mn0 - mn1 : mn1 - mn0;

    cmd.start        = (req_type == lr_pkg::REQ_START);
    cmd.major_pos    = mj0;
    cmd.major_end    = mj1;
    cmd.minor_pos    = mn0;
    cmd.major_delta  = mj1 - mj0;
    cmd.minor_delta  = mn_delta;
    cmd.minor_down   = down;
    cmd.axes_swapped = y_major;
    cmd.error_init   = {2'b0, mn_delta, 1'b0} - {3'b0, (mj1 - mj0)};
  end

endmodule

[rtl/lr_cmd_queue.sv]
// short command queue between the front end and the pixel stepper
`timescale 1ns / 1ps

module lr_cmd_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  lr_pkg::cmd_t wr_cmd,
  output logic         q_full,
  input  logic         rd_en,
  output lr_pkg::cmd_t rd_cmd,
  output logic         q_valid
);

  lr_pkg::cmd_t                mem_r [lr_pkg::CMDQ_DEPTH];
  logic [lr_pkg::CMDQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lr_pkg::CMDQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lr_pkg::CMDQ_AW:0]    count_r, count_nxt;
  logic                        do_wr, do_rd;

  assign q_full  = (count_r == (lr_pkg::CMDQ_AW+1)'(lr_pkg::CMDQ_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[rtl/lr_back.sv]
// back end: line state, bresenham stepping and the result register
`timescale 1ns / 1ps

module lr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lr_pkg::cmd_t   cmd,
  output logic           cmd_take,
  output logic           empty,
  input  logic           pop,
  output logic           out_pixel_valid,
  output lr_pkg::coord_t out_pixel_x,
  output lr_pkg::coord_t out_pixel_y,
  output logic           out_line_done
);

  logic                            active_r, active_nxt;
  lr_pkg::coord_t                  major_pos_r, major_pos_nxt;
  lr_pkg::coord_t                  major_end_r, major_end_nxt;
  lr_pkg::coord_t                  minor_pos_r, minor_pos_nxt;
  lr_pkg::coord_t                  major_delta_r, major_delta_nxt;
  lr_pkg::coord_t                  minor_delta_r, minor_delta_nxt;
  logic                            minor_down_r, minor_down_nxt;
  logic                            axes_swapped_r, axes_swapped_nxt;
  logic signed [lr_pkg::ERR_W-1:0] error_r, error_nxt;

  logic                            out_full_r, out_full_nxt;
  logic                            pix_valid_r, pix_valid_nxt;
  lr_pkg::coord_t                  pix_x_r, pix_x_nxt;
  lr_pkg::coord_t                  pix_y_r, pix_y_nxt;
  logic                            done_r, done_nxt;

  logic                            emit;
  logic                            last;

  assign cmd_take        = cmd_valid && (!out_full_r || pop);
  assign empty           = !out_full_r;
  assign out_pixel_valid = pix_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_line_done   = done_r;

  always_comb begin
    // a start transaction loads the line, a step uses the held line
    if (cmd.start) begin
      major_pos_nxt    = cmd.major_pos;
      major_end_nxt    = cmd.major_end;
      minor_pos_nxt    = cmd.minor_pos;
      major_delta_nxt  = cmd.major_delta;
      minor_delta_nxt  = cmd.minor_delta;
      minor_down_nxt   = cmd.minor_down;
      axes_swapped_nxt = cmd.axes_swapped;
      error_nxt        = cmd.error_init;
    end else begin
      major_pos_nxt    = major_pos_r;
      major_end_nxt    = major_end_r;
      minor_pos_nxt    = minor_pos_r;
      major_delta_nxt  = major_delta_r;
      minor_delta_nxt  = minor_delta_r;
      minor_down_nxt   = minor_down_r;
      axes_swapped_nxt = axes_swapped_r;
      error_nxt        = error_r;
    end
    active_nxt = active_r;
    emit       = cmd_take && (cmd.start || active_r);
    last       = (major_pos_nxt == major_end_nxt);

    pix_valid_nxt = pix_valid_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    done_nxt      = done_r;

    if (cmd_take) begin
      pix_valid_nxt = emit;
      pix_x_nxt     = '0;
      pix_y_nxt     = '0;
      done_nxt      = 1'b0;
      if (emit) begin
        pix_x_nxt  = axes_swapped_nxt ? minor_pos_nxt : major_pos_nxt;
        pix_y_nxt  = axes_swapped_nxt ? major_pos_nxt : minor_pos_nxt;
        done_nxt   = last;
        active_nxt = !last;
        if (!last) begin
          if (error_nxt > 0) begin
            minor_pos_nxt = minor_down_nxt ? minor_pos_nxt - 1'b1 : minor_pos_nxt + 1'b1;
            error_nxt     = error_nxt + ({2'b0, minor_delta_nxt, 1'b0}
                                         - {2'b0, major_delta_nxt, 1'b0});
          end else begin
            error_nxt = error_nxt + {2'b0, minor_delta_nxt, 1'b0};
          end
          major_pos_nxt = major_pos_nxt + 1'b1;
        end
      end
    end

    if (!emit) begin
      major_pos_nxt    = major_pos_r;
      major_end_nxt    = major_end_r;
      minor_pos_nxt    = minor_pos_r;
      major_delta_nxt  = major_delta_r;
      minor_delta_nxt  = minor_delta_r;
      minor_down_nxt   = minor_down_r;
      axes_swapped_nxt = axes_swapped_r;
      error_nxt        = error_r;
    end

    out_full_nxt = cmd_take || (out_full_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      major_pos_r    <= '0;
      major_end_r    <= '0;
      minor_pos_r    <= '0;
      major_delta_r  <= '0;
      minor_delta_r  <= '0;
      minor_down_r   <= 1'b0;
      axes_swapped_r <= 1'b0;
      error_r        <= '0;
      out_full_r     <= 1'b0;
    end else begin
      active_r       <= active_nxt;
      major_pos_r    <= major_pos_nxt;
      major_end_r    <= major_end_nxt;
      minor_pos_r    <= minor_pos_nxt;
      major_delta_r  <= major_delta_nxt;
      minor_delta_r  <= minor_delta_nxt;
      minor_down_r   <= minor_down_nxt;
      axes_swapped_r <= axes_swapped_nxt;
      error_r        <= error_nxt;
      out_full_r     <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_valid_r <= pix_valid_nxt;
    pix_x_r     <= pix_x_nxt;
    pix_y_r     <= pix_y_nxt;
    done_r      <= done_nxt;
  end

endmodule

[rtl/line_rasterizer.sv]
// top level of the bresenham line rasterizer
//
//   channel   ports                                         transaction when
//   request   push, full, in_req_type, in_from_*, in_to_*   push && !full
//   pixel     empty, pop, out_pixel_*, out_line_done        pop && !empty
//
// one pixel per cycle sustained while pop keeps up; a request goes from the
// command queue to the pixel register. the stepper's add and compare on the
// error term sets that rate. synchronous active low reset leaves the block
// idle. a stalled pixel output fills the two-entry command queue, then full
// rises; requests keep flowing while a pixel waits for pop.
`timescale 1ns / 1ps

module line_rasterizer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic           in_req_type,
  input  lr_pkg::coord_t in_from_x,
  input  lr_pkg::coord_t in_from_y,
  input  lr_pkg::coord_t in_to_x,
  input  lr_pkg::coord_t in_to_y,
  output logic           empty,
  input  logic           pop,
  output logic           out_pixel_valid,
  output lr_pkg::coord_t out_pixel_x,
  output lr_pkg::coord_t out_pixel_y,
  output logic           out_line_done
);

  lr_pkg::cmd_t front_cmd;
  lr_pkg::cmd_t q_cmd;
  logic         q_valid;
  logic         q_take;

  lr_front u_front (
    .req_type (in_req_type),
    .from_x   (in_from_x),
    .from_y   (in_from_y),
    .to_x     (in_to_x),
    .to_y     (in_to_y),
    .cmd      (front_cmd)
  );

  lr_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_cmd  (front_cmd),
    .q_full  (full),
    .rd_en   (q_take),
    .rd_cmd  (q_cmd),
    .q_valid (q_valid)
  );

  lr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (q_cmd),
    .cmd_take        (q_take),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_line_done   (out_line_done)
  );

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the line rasterizer with a built-in pixel predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_LIMIT   = 5000;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [lr_pkg::ERR_W-1:0] err_t;

  typedef struct packed {
    logic           valid;
    lr_pkg::coord_t x;
    lr_pkg::coord_t y;
    logic           done;
  } pixel_t;

  typedef struct {
    logic           req;
    lr_pkg::coord_t fx;
    lr_pkg::coord_t fy;
    lr_pkg::coord_t tx;
    lr_pkg::coord_t ty;
    bit             known;
    pixel_t         want;
  } stim_row_t;

  logic           clk;
  logic           rst_n;
  logic           push;
  logic           full;
  logic           in_req_type;
  lr_pkg::coord_t in_from_x;
  lr_pkg::coord_t in_from_y;
  lr_pkg::coord_t in_to_x;
  lr_pkg::coord_t in_to_y;
  logic           empty;
  logic           pop;
  logic           out_pixel_valid;
  lr_pkg::coord_t out_pixel_x;
  lr_pkg::coord_t out_pixel_y;
  logic           out_line_done;

  // predictor state
  logic           line_active;
  lr_pkg::coord_t maj_pos;
  lr_pkg::coord_t maj_end;
  lr_pkg::coord_t min_pos;
  lr_pkg::coord_t maj_delta;
  lr_pkg::coord_t min_delta;
  logic           min_down;
  logic           y_major;
  err_t           err_acc;

  pixel_t    pixel_q[$];
  stim_row_t stim_rows[$];
  int        fail_count;
  int        idle_cycles;
  int        random_sent;
  int        stall_left;
  bit        quiet;

  line_rasterizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_from_x       (in_from_x),
    .in_from_y       (in_from_y),
    .in_to_x         (in_to_x),
    .in_to_y         (in_to_y),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_line_done   (out_line_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v >= lr_pkg::FRAME_SIZE) return lr_pkg::FRAME_SIZE - 1;
    return v;
  endfunction

  function automatic pixel_t predict_pixel(input logic req, input lr_pkg::coord_t fx_i,
                                           input lr_pkg::coord_t fy_i,
                                           input lr_pkg::coord_t tx_i,
                                           input lr_pkg::coord_t ty_i);
    pixel_t p;
    int     fx, fy, tx, ty, adx, ady, mj0, mj1, mn0, mn1;
    p = '0;
    if (req == lr_pkg::REQ_START) begin
      fx  = clamp_coord(int'(fx_i));
      fy  = clamp_coord(int'(fy_i));
      tx  = clamp_coord(int'(tx_i));
      ty  = clamp_coord(int'(ty_i));
      adx = (tx > fx) ? tx - fx : fx - tx;
      ady = (ty > fy) ? ty - fy : fy - ty;
      if (ady < adx) begin
        y_major = 1'b0;
        if (fx > tx) begin
          mj0 = tx; mj1 = fx; mn0 = ty; mn1 = fy;
        end else begin
          mj0 = fx; mj1 = tx; mn0 = fy; mn1 = ty;
        end
      end else begin
        y_major = 1'b1;
        if (fy > ty) begin
          mj0 = ty; mj1 = fy; mn0 = tx; mn1 = fx;
        end else begin
          mj0 = fy; mj1 = ty; mn0 = fx; mn1 = tx;
        end
      end
      maj_pos     = lr_pkg::coord_t'(mj0);
      maj_end     = lr_pkg::coord_t'(mj1);
      min_pos     = lr_pkg::coord_t'(mn0);
      maj_delta   = lr_pkg::coord_t'(mj1 - mj0);
      min_down    = (mn1 < mn0);
      min_delta   = lr_pkg::coord_t'(min_down ? mn0 - mn1 : mn1 - mn0);
      err_acc     = err_t'(2 * int'(min_delta) - int'(maj_delta));
      line_active = 1'b1;
    end else if (!line_active) begin
      return p;
    end
    p.valid = 1'b1;
    p.x     = y_major ? min_pos : maj_pos;
    p.y     = y_major ? maj_pos : min_pos;
    p.done  = (maj_pos == maj_end);
    if (p.done) begin
      line_active = 1'b0;
    end else begin
      if (err_acc > 0) begin
        min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
        err_acc = err_t'(int'(err_acc) + 2 * (int'(min_delta) - int'(maj_delta)));
      end else begin
        err_acc = err_t'(int'(err_acc) + 2 * int'(min_delta));
      end
      maj_pos = maj_pos + 1'b1;
    end
    return p;
  endfunction

  function automatic void add_row(input logic req, input int fx, input int fy, input int tx,
                                  input int ty, input bit known, input logic v,
                                  input int x, input int y, input logic d);
    stim_row_t row;
    row.req   = req;
    row.fx    = lr_pkg::coord_t'(fx);
    row.fy    = lr_pkg::coord_t'(fy);
    row.tx    = lr_pkg::coord_t'(tx);
    row.ty    = lr_pkg::coord_t'(ty);
    row.known = known;
    row.want  = '{valid: v, x: lr_pkg::coord_t'(x), y: lr_pkg::coord_t'(y), done: d};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // drive one request, wait for its transaction and record the expected pixel
  task automatic send(input logic req, input lr_pkg::coord_t fx, input lr_pkg::coord_t fy,
                      input lr_pkg::coord_t tx, input lr_pkg::coord_t ty, input bit known,
                      input pixel_t want);
    int     gap;
    pixel_t p;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push        <= 1'b1;
    in_req_type <= req;
    in_from_x   <= fx;
    in_from_y   <= fy;
    in_to_x     <= tx;
    in_to_y     <= ty;
    @(posedge clk);
    while (full) @(posedge clk);
    p = predict_pixel(req, fx, fy, tx, ty);
    if (known) p = want;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic send_step();
    send(lr_pkg::REQ_STEP, lr_pkg::coord_t'($urandom), lr_pkg::coord_t'($urandom),
         lr_pkg::coord_t'($urandom), lr_pkg::coord_t'($urandom), 1'b0, '0);
    random_sent++;
  endtask

  task automatic send_start(input int fx, input int fy, input int tx, input int ty);
    send(lr_pkg::REQ_START, lr_pkg::coord_t'(fx), lr_pkg::coord_t'(fy),
         lr_pkg::coord_t'(tx), lr_pkg::coord_t'(ty), 1'b0, '0);
    random_sent++;
  endtask

  // pixel side
  initial begin
    pop        = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && pop && !empty) begin
      if (pixel_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected pixel: v=%0d x=%0d y=%0d done=%0d", out_pixel_valid,
                   out_pixel_x, out_pixel_y, out_line_done);
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_valid !== want.valid || out_pixel_x !== want.x ||
            out_pixel_y !== want.y || out_line_done !== want.done) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: exp v=%0d x=%0d y=%0d d=%0d, got v=%0d x=%0d y=%0d d=%0d",
                     want.valid, want.x, want.y, want.done, out_pixel_valid, out_pixel_x,
                     out_pixel_y, out_line_done);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int fx, fy, tx, ty, r;
    fail_count  = 0;
    idle_cycles = 0;
    random_sent = 0;
    quiet       = 1'b0;
    line_active = 1'b0;
    maj_pos     = '0;
    maj_end     = '0;
    min_pos     = '0;
    maj_delta   = '0;
    min_delta   = '0;
    min_down    = 1'b0;
    y_major     = 1'b0;
    err_acc     = '0;
    rst_n       = 1'b0;
    push        = 1'b0;
    in_req_type = lr_pkg::REQ_START;
    in_from_x   = '0;
    in_from_y   = '0;
    in_to_x     = '0;
    in_to_y     = '0;

    // step while idle, single pixel lines, corners
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 1, 1'b0, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_START, 0, 0, 0, 0, 1, 1'b1, 0, 0, 1'b1);
    add_row(lr_pkg::REQ_STEP,  511, 511, 511, 511, 1, 1'b0, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_START, 511, 511, 511, 511, 1, 1'b1, 511, 511, 1'b1);
    // full width horizontal line, abandoned by a new start
    add_row(lr_pkg::REQ_START, 0, 0, 511, 0, 1, 1'b1, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    // equal deltas pick y, minor axis descending
    add_row(lr_pkg::REQ_START, 511, 0, 0, 511, 1, 1'b1, 511, 0, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    // x major with swapped endpoints
    add_row(lr_pkg::REQ_START, 20, 10, 4, 14, 1, 1'b1, 4, 14, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(lr_pkg::REQ_STEP,  0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
    // y major with swapped endpoints, run to the end and past it
    add_row(lr_pkg::REQ_START, 100, 300, 103, 290, 1, 1'b1, 103, 290, 1'b0);
    for (int i = 0; i < 11; i++)
      add_row(lr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send(stim_rows[i].req, stim_rows[i].fx, stim_rows[i].fy, stim_rows[i].tx,
           stim_rows[i].ty, stim_rows[i].known, stim_rows[i].want);

    while (random_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      r     = $urandom_range(0, 99);
      fx    = $urandom_range(0, 511);
      fy    = $urandom_range(0, 511);
      if (r < 80) begin
        // well-formed line, mostly short, then steps, usually until its last pixel
        if ($urandom_range(0, 19) == 0) begin
          tx = $urandom_range(0, 511);
          ty = $urandom_range(0, 511);
        end else begin
          tx = clamp_coord(fx + $urandom_range(0, 24) - 12);
          ty = clamp_coord(fy + $urandom_range(0, 24) - 12);
        end
        send_start(fx, fy, tx, ty);
        while (line_active && random_sent < RANDOM_ITEMS && $urandom_range(0, 99) < 97)
          send_step();
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) send_step();
      end else begin
        send_start(fx, fy, $urandom_range(0, 511), $urandom_range(0, 511));
        repeat ($urandom_range(0, 3)) send_step();
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
